>>> rtl/lsg_pkg.sv
package lsg_pkg;

    localparam int LEVEL_W   = 32;
    localparam int STEPS_W   = 16;
    localparam int CFG_IDX_W = 3;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_START  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEPS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WRAP   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GROWTH = 3'd5;

    // Loop mode codes. The fourth code behaves as never loop.
    localparam logic [1:0] WRAP_NONE  = 2'd0;
    localparam logic [1:0] WRAP_COUNT = 2'd1;
    localparam logic [1:0] WRAP_LIMIT = 2'd2;

    localparam logic GROW_ADD = 1'b0;
    localparam logic GROW_MUL = 1'b1;

    localparam logic ACT_NEXT = 1'b0;
    localparam logic ACT_SET  = 1'b1;

    typedef struct packed {
        logic                      action;
        logic signed [LEVEL_W-1:0] new_level;
    } t_in_item;

    typedef struct packed {
        logic signed [LEVEL_W-1:0] level_out;
        logic                      wrapped;
        logic                      clipped;
    } t_out_item;

    typedef struct packed {
        logic signed [LEVEL_W-1:0] start_level;
        logic signed [LEVEL_W-1:0] step_amount;
        logic signed [LEVEL_W-1:0] limit_level;
        logic [STEPS_W-1:0]        steps_per_loop;
        logic [1:0]                wrap_mode;
        logic                      growth_kind;
    } t_cfg;

    // Outcome of one advance, excluding the step counter.
    typedef struct packed {
        logic signed [LEVEL_W-1:0] next_level;
        logic                      wrapped;
        logic                      clipped;
    } t_adv;

endpackage

>>> rtl/lsg_cfg_regs.sv
module lsg_cfg_regs
    import lsg_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [LEVEL_W-1:0]   i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_START:  r_cfg.start_level    <= signed'(i_cfg_data);
                REG_STEP:   r_cfg.step_amount    <= signed'(i_cfg_data);
                REG_LIMIT:  r_cfg.limit_level    <= signed'(i_cfg_data);
                REG_STEPS:  r_cfg.steps_per_loop <= i_cfg_data[STEPS_W-1:0];
                REG_WRAP:   r_cfg.wrap_mode      <= i_cfg_data[1:0];
                REG_GROWTH: r_cfg.growth_kind    <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/lsg_advance.sv
module lsg_advance
    import lsg_pkg::*;
#(
    parameter int FRAC_BITS  = 16,
    parameter int COUNT_BITS = 16
) (
    input  t_cfg                      i_cfg,
    input  logic signed [LEVEL_W-1:0] i_level,
    input  logic [COUNT_BITS-1:0]     i_pos,
    output t_adv                      o_adv,
    output logic [COUNT_BITS-1:0]     o_pos
);

    localparam int PROD_W = 2 * LEVEL_W;
    localparam int CMP_W  = (COUNT_BITS + 1 > STEPS_W) ? COUNT_BITS + 1 : STEPS_W;

    logic signed [LEVEL_W:0]   sum;
    logic signed [PROD_W-1:0]  prod;
    logic signed [PROD_W-1:0]  scaled;
    logic                      sum_hi, sum_lo, mul_hi, mul_lo;
    logic signed [LEVEL_W-1:0] grown;
    logic                      sat;
    logic [CMP_W-1:0]          cnt;
    logic                      loop;
    logic                      limit_up;

    assign sum    = {i_level[LEVEL_W-1], i_level}
                  + {i_cfg.step_amount[LEVEL_W-1], i_cfg.step_amount};
    assign prod   = PROD_W'(i_level) * PROD_W'(i_cfg.step_amount);
    // Arithmetic shift rounds toward minus infinity.
    assign scaled = prod >>> FRAC_BITS;

    assign sum_hi = !sum[LEVEL_W] &&  sum[LEVEL_W-1];
    assign sum_lo =  sum[LEVEL_W] && !sum[LEVEL_W-1];
    assign mul_hi = !scaled[PROD_W-1] &&  (|scaled[PROD_W-2:LEVEL_W-1]);
    assign mul_lo =  scaled[PROD_W-1] && !(&scaled[PROD_W-2:LEVEL_W-1]);

    always_comb begin
        sat   = 1'b0;
        grown = '0;
        case (i_cfg.growth_kind)
            GROW_MUL: begin
                sat = mul_hi || mul_lo;
                if (mul_hi) begin
                    grown = {1'b0, {(LEVEL_W-1){1'b1}}};
                end else if (mul_lo) begin
                    grown = {1'b1, {(LEVEL_W-1){1'b0}}};
                end else begin
                    grown = scaled[LEVEL_W-1:0];
                end
            end
            default: begin
                sat = sum_hi || sum_lo;
                if (sum_hi) begin
                    grown = {1'b0, {(LEVEL_W-1){1'b1}}};
                end else if (sum_lo) begin
                    grown = {1'b1, {(LEVEL_W-1){1'b0}}};
                end else begin
                    grown = sum[LEVEL_W-1:0];
                end
            end
        endcase
    end

    assign cnt      = CMP_W'(i_pos) + CMP_W'(1);
    assign limit_up = i_cfg.limit_level > i_cfg.start_level;

    always_comb begin
        loop  = 1'b0;
        o_pos = i_pos;
        unique case (i_cfg.wrap_mode)
            WRAP_COUNT: begin
                if (cnt >= CMP_W'(i_cfg.steps_per_loop)) begin
                    loop  = 1'b1;
                    o_pos = '0;
                end else begin
                    // Past the counter range it wraps to zero.
                    o_pos = cnt[COUNT_BITS-1:0];
                end
            end
            WRAP_LIMIT: begin
                if (limit_up) begin
                    loop = grown >= i_cfg.limit_level;
                end else begin
                    loop = grown <= i_cfg.limit_level;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_adv.next_level = loop ? i_cfg.start_level : grown;
    assign o_adv.wrapped    = loop;
    assign o_adv.clipped    = sat;

endmodule

>>> rtl/looping_sequence_generator.sv
// Channel   Direction  Handshake                  Beat
// input     in         i_in_valid / o_in_stall    t_in_item  (action, new_level)
// output    out        o_out_valid / i_out_stall  t_out_item (level_out, wrapped, clipped)
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One beat is accepted every cycle while o_in_stall is low. A beat sits in the input
// register, where the combinational add or multiply, saturation and loop test run
// against the held level, and the result lands in the output register.
// Reset is synchronous and clears the valid flags, the configuration, the level and the step counter.
// A stalled output holds its result; the input keeps flowing until a next request
// finds the output still full, and set requests never wait on the output.
module looping_sequence_generator
    import lsg_pkg::*;
#(
    parameter int FRAC_BITS  = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [LEVEL_W-1:0]   i_cfg_data
);

    t_cfg                      cfg;
    t_adv                      adv;
    logic [COUNT_BITS-1:0]     adv_pos;

    logic                      r_in_valid;
    t_in_item                  r_in;
    logic                      r_out_valid;
    t_out_item                 r_out;
    logic signed [LEVEL_W-1:0] r_level;
    logic [COUNT_BITS-1:0]     r_pos;

    logic                      proc_go;
    logic                      in_take;
    logic                      start_wr;

    lsg_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    lsg_advance #(
        .FRAC_BITS  (FRAC_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_adv (
        .i_cfg   (cfg),
        .i_level (r_level),
        .i_pos   (r_pos),
        .o_adv   (adv),
        .o_pos   (adv_pos)
    );

    assign o_cfg_ready = 1'b1;
    assign start_wr    = i_cfg_valid && (i_cfg_index == REG_START);

    // A next request needs room in the output register; a set request does not.
    assign proc_go    = r_in_valid &&
                        !((r_in.action == ACT_NEXT) && r_out_valid && i_out_stall);
    assign o_in_stall = r_in_valid && !proc_go;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (proc_go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_go && (r_in.action == ACT_NEXT)) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_go && (r_in.action == ACT_NEXT)) begin
            r_out.level_out <= r_level;
            r_out.wrapped   <= adv.wrapped;
            r_out.clipped   <= adv.clipped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
            r_pos   <= '0;
        end else if (start_wr) begin
            r_level <= signed'(i_cfg_data);
        end else if (proc_go) begin
            if (r_in.action == ACT_SET) begin
                r_level <= r_in.new_level;
            end else begin
                r_level <= adv.next_level;
                r_pos   <= adv_pos;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import lsg_pkg::*;

    localparam int FRAC_BITS      = 16;
    localparam int COUNT_BITS     = 16;
    localparam int SETTLE_CYCLES  = 4;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PRINT_CAP      = 50;
    localparam int PHASE_ITEMS    = 307;

    // Loop mode code that the block treats as never loop.
    localparam logic [1:0] WRAP_SPARE = 2'd3;
    // Register indexes with no register behind them.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    localparam logic signed [LEVEL_W-1:0] LEVEL_ONE = 32'sh0001_0000;
    localparam logic signed [LEVEL_W-1:0] LEVEL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [LEVEL_W-1:0] LEVEL_MIN = 32'sh8000_0000;
    localparam longint LEVEL_TOP    = 64'sd2147483647;
    localparam longint LEVEL_BOTTOM = -64'sd2147483648;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    t_in_item             i_in_data;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_item            o_out_data;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [LEVEL_W-1:0]   i_cfg_data;

    // Predictor state: register copy, held level and step counter.
    t_cfg                        gen_cfg;
    logic signed [LEVEL_W-1:0]   gen_level;
    logic [COUNT_BITS-1:0]       gen_pos;
    t_out_item                   level_q[$];

    int err_count      = 0;
    int items_sent     = 0;
    int results_seen   = 0;
    int cfg_writes     = 0;
    int loops_seen     = 0;
    int clips_seen     = 0;
    int quiet_cycles   = 0;
    int send_idle_pct  = 30;
    int sink_stall_pct = 69;

    looping_sequence_generator #(
        .FRAC_BITS  (FRAC_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < sink_stall_pct);
    end

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [LEVEL_W-1:0] data);
        case (idx)
            REG_START: begin
                gen_cfg.start_level = data;
                gen_level = data;
            end
            REG_STEP:   gen_cfg.step_amount = data;
            REG_LIMIT:  gen_cfg.limit_level = data;
            REG_STEPS:  gen_cfg.steps_per_loop = data[STEPS_W-1:0];
            REG_WRAP:   gen_cfg.wrap_mode = data[1:0];
            REG_GROWTH: gen_cfg.growth_kind = data[0];
            default: ;
        endcase
    endfunction

    // Returns the beat for one next request and moves the level and counter on.
    function automatic t_out_item advance_level();
        longint           held;
        longint           factor;
        longint           raw;
        longint           lim;
        longint           base;
        logic [COUNT_BITS:0] cnt;
        t_out_item        r;
        held   = $signed(gen_level);
        factor = $signed(gen_cfg.step_amount);
        if (gen_cfg.growth_kind == GROW_MUL) begin
            raw = (held * factor) >>> FRAC_BITS;
        end else begin
            raw = held + factor;
        end
        r.clipped = 1'b0;
        if (raw > LEVEL_TOP) begin
            raw = LEVEL_TOP;
            r.clipped = 1'b1;
        end else if (raw < LEVEL_BOTTOM) begin
            raw = LEVEL_BOTTOM;
            r.clipped = 1'b1;
        end
        r.wrapped = 1'b0;
        case (gen_cfg.wrap_mode)
            WRAP_COUNT: begin
                cnt = {1'b0, gen_pos} + 1'b1;
                if (cnt >= gen_cfg.steps_per_loop) begin
                    gen_pos = '0;
                    r.wrapped = 1'b1;
                end else begin
                    gen_pos = cnt[COUNT_BITS-1:0];
                end
            end
            WRAP_LIMIT: begin
                lim  = $signed(gen_cfg.limit_level);
                base = $signed(gen_cfg.start_level);
                r.wrapped = (lim > base) ? (raw >= lim) : (raw <= lim);
            end
            default: ;
        endcase
        r.level_out = gen_level;
        gen_level = r.wrapped ? gen_cfg.start_level : raw[LEVEL_W-1:0];
        return r;
    endfunction

    function automatic t_cfg make_cfg(input logic [LEVEL_W-1:0] start,
                                      input logic [LEVEL_W-1:0] step,
                                      input logic [LEVEL_W-1:0] limit,
                                      input logic [STEPS_W-1:0] steps,
                                      input logic [1:0] wrap,
                                      input logic grow);
        t_cfg c;
        c.start_level    = start;
        c.step_amount    = step;
        c.limit_level    = limit;
        c.steps_per_loop = steps;
        c.wrap_mode      = wrap;
        c.growth_kind    = grow;
        return c;
    endfunction

    // Mostly levels within a few units either side of zero, sometimes any pattern.
    function automatic logic [LEVEL_W-1:0] random_level();
        if ($urandom_range(3) == 0) begin
            return $urandom();
        end
        return $urandom_range(32'h000C_0000) - 32'h0006_0000;
    endfunction

    function automatic t_cfg random_cfg();
        t_cfg               c;
        int                 pick;
        logic [LEVEL_W-1:0] mag;
        pick = $urandom_range(9);
        c.wrap_mode = (pick == 0) ? WRAP_NONE :
                      (pick == 1) ? WRAP_SPARE :
                      (pick < 6)  ? WRAP_COUNT : WRAP_LIMIT;
        c.growth_kind = $urandom_range(1);
        c.start_level = random_level();
        c.limit_level = ($urandom_range(3) == 0) ? $urandom() :
                        c.start_level + random_level();
        c.steps_per_loop = ($urandom_range(5) == 0) ? $urandom_range(65535) :
                           $urandom_range(12);
        if ($urandom_range(4) == 0) begin
            c.step_amount = $urandom();
        end else if (c.growth_kind == GROW_MUL) begin
            // Factors between one half and three halves keep the level alive.
            c.step_amount = LEVEL_ONE + $urandom_range(32'h0001_0000) - 32'h0000_8000;
            if ($urandom_range(4) == 0) begin
                c.step_amount = -c.step_amount;
            end
        end else if (c.wrap_mode == WRAP_LIMIT && $urandom_range(3) != 0) begin
            // Head toward the limit so that crossings actually happen.
            mag = $urandom_range(1, 32'h0002_0000);
            c.step_amount = (c.limit_level > c.start_level) ? mag : -mag;
        end else begin
            c.step_amount = $urandom_range(32'h0004_0000) - 32'h0002_0000;
        end
        return c;
    endfunction

    task automatic report_mismatch(input string what, input logic [LEVEL_W-1:0] want,
                                   input logic [LEVEL_W-1:0] got);
        err_count++;
        if (err_count <= PRINT_CAP) begin
            $display("[%0t] MISMATCH %s: expected %h, got %h", $time, what, want, got);
        end
    endtask

    task automatic send_item(input t_in_item item);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
        if (item.action == ACT_SET) begin
            gen_level = item.new_level;
        end else begin
            level_q.push_back(advance_level());
        end
    endtask

    task automatic next_req();
        t_in_item item;
        item.action    = ACT_NEXT;
        item.new_level = $urandom();
        send_item(item);
    endtask

    task automatic set_req(input logic [LEVEL_W-1:0] lvl);
        t_in_item item;
        item.action    = ACT_SET;
        item.new_level = lvl;
        send_item(item);
    endtask

    // Holds the input back until every result is out, then lets a set request
    // that may still be in flight settle.
    task automatic quiesce();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (level_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEVEL_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_reg(idx, data);
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // With noise set, the bits above each narrow register carry random junk.
    task automatic load_config(input t_cfg c, input logic noise);
        logic [LEVEL_W-1:0] junk;
        junk = noise ? $urandom() : '0;
        quiesce();
        write_reg(REG_START, c.start_level);
        write_reg(REG_STEP, c.step_amount);
        write_reg(REG_LIMIT, c.limit_level);
        write_reg(REG_STEPS, {junk[LEVEL_W-1:STEPS_W], c.steps_per_loop});
        write_reg(REG_WRAP, {junk[LEVEL_W-1:2], c.wrap_mode});
        write_reg(REG_GROWTH, {junk[LEVEL_W-1:1], c.growth_kind});
    endtask

    task automatic test_reset_state();
        next_req();
        next_req();
        set_req(32'sh0003_0000);
        next_req();
    endtask

    task automatic test_series_clip();
        load_config(make_cfg(32'sh7FFF_0000, LEVEL_ONE, '0, '0, WRAP_NONE, GROW_ADD), 1'b0);
        next_req();
        next_req();
        load_config(make_cfg(LEVEL_MIN, LEVEL_MIN, '0, '0, WRAP_NONE, GROW_ADD), 1'b0);
        next_req();
        load_config(make_cfg('0, LEVEL_MAX, '0, '0, WRAP_NONE, GROW_ADD), 1'b0);
        next_req();
        next_req();
    endtask

    task automatic test_geometric();
        load_config(make_cfg(LEVEL_ONE, 32'sh0001_8000, '0, '0, WRAP_NONE, GROW_MUL), 1'b0);
        next_req();
        next_req();
        // A negative product with fraction bits set must round down.
        load_config(make_cfg(32'sd3, 32'shFFFF_8000, '0, '0, WRAP_NONE, GROW_MUL), 1'b0);
        next_req();
        next_req();
        load_config(make_cfg(32'sh4000_0000, LEVEL_MAX, '0, '0, WRAP_NONE, GROW_MUL), 1'b0);
        next_req();
        set_req(LEVEL_MIN);
        quiesce();
        write_reg(REG_STEP, LEVEL_MIN);
        next_req();
    endtask

    task automatic test_count_loop();
        load_config(make_cfg(LEVEL_ONE, LEVEL_ONE, '0, '0, WRAP_COUNT, GROW_ADD), 1'b0);
        next_req();
        quiesce();
        write_reg(REG_STEPS, 32'd2);
        next_req();
        next_req();
        next_req();
        // The counter keeps its place while another mode is active.
        quiesce();
        write_reg(REG_WRAP, WRAP_NONE);
        next_req();
        quiesce();
        write_reg(REG_WRAP, WRAP_COUNT);
        next_req();
    endtask

    task automatic test_limit_loop();
        load_config(make_cfg('0, LEVEL_ONE, 32'sh0002_0000, '0, WRAP_LIMIT, GROW_ADD), 1'b0);
        next_req();
        next_req();
        load_config(make_cfg('0, -LEVEL_ONE, -LEVEL_ONE, '0, WRAP_LIMIT, GROW_ADD), 1'b0);
        next_req();
        // Limit equal to start counts as a falling bound.
        load_config(make_cfg(LEVEL_ONE, '0, LEVEL_ONE, '0, WRAP_LIMIT, GROW_ADD), 1'b0);
        next_req();
        // Saturation is still flagged when the loop replaces the clipped level.
        load_config(make_cfg(32'sh7000_0000, 32'sh7000_0000, LEVEL_MAX, '0, WRAP_LIMIT,
                             GROW_ADD), 1'b0);
        next_req();
        next_req();
    endtask

    task automatic test_unused_codes();
        load_config(make_cfg(LEVEL_ONE, LEVEL_ONE, '0, '0, WRAP_SPARE, GROW_ADD), 1'b1);
        next_req();
        next_req();
        quiesce();
        write_reg(REG_SPARE_A, $urandom());
        write_reg(REG_SPARE_B, $urandom());
        next_req();
    endtask

    task automatic test_random(input int idle_pct, input int stall_pct, input int n_items);
        int sent;
        int burst;
        sent = 0;
        send_idle_pct  = idle_pct;
        sink_stall_pct = stall_pct;
        while (sent < n_items) begin
            load_config(random_cfg(), $urandom_range(1));
            burst = $urandom_range(8, 48);
            repeat (burst) begin
                if ($urandom_range(99) < 12) begin
                    set_req(random_level());
                end else begin
                    next_req();
                end
                sent++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (level_q.size() == 0) begin
                report_mismatch("result beat with nothing expected", '0, o_out_data.level_out);
            end else begin
                want = level_q.pop_front();
                loops_seen += want.wrapped;
                clips_seen += want.clipped;
                if (o_out_data.level_out !== want.level_out) begin
                    report_mismatch("level_out", want.level_out, o_out_data.level_out);
                end
                if (o_out_data.wrapped !== want.wrapped) begin
                    report_mismatch("wrapped", want.wrapped, o_out_data.wrapped);
                end
                if (o_out_data.clipped !== want.clipped) begin
                    report_mismatch("clipped", want.clipped, o_out_data.clipped);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] no beat moved for %0d cycles, %0d results outstanding",
                     $time, WATCHDOG_LIMIT, level_q.size());
            $display("** looping_sequence_generator: FAILED **");
            $finish;
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        gen_cfg     = '0;
        gen_level   = '0;
        gen_pos     = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_series_clip();
        test_geometric();
        test_count_loop();
        test_limit_loop();
        test_unused_codes();
        test_random(30, 69, PHASE_ITEMS);
        test_random(69, 30, PHASE_ITEMS);
        test_random(0, 0, PHASE_ITEMS);

        quiesce();
        repeat (8) @(posedge i_clk);
        $display("Sent %0d request beats over %0d register writes; checked %0d results,",
                 items_sent, cfg_writes, results_seen);
        $display("of which %0d reloaded on a loop and %0d saturated; %0d mismatches.",
                 loops_seen, clips_seen, err_count);
        if (err_count == 0) begin
            $display("** looping_sequence_generator: PASSED **");
        end else begin
            $display("** looping_sequence_generator: FAILED **");
        end
        $finish;
    end

endmodule
